// ----- hdl/broadcast_fifo_multi_reader_unit_defines.svh -----
// assertion macros for the broadcast fifo top level
`ifndef BROADCAST_FIFO_MULTI_READER_UNIT_DEFINES_SVH
`define BROADCAST_FIFO_MULTI_READER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BFMR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BFMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bfmr_pkg.sv -----
// shared constants, types and helpers of the broadcast fifo
package bfmr_pkg;

    localparam int DEPTH    = 16;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int MAX_CONS = 8;
    localparam int CID_W    = 3;
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 4;
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 2;
    localparam int QDEPTH   = 4;
    localparam int QADDR_W  = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // request type codes on the input channel
    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BADC  = 2'd3
    } t_status;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_PUSH  = 3'd1,
        OP_POP   = 3'd2,
        OP_CLEAR = 3'd3,
        OP_BADC  = 3'd4
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] data;
        logic [CID_W-1:0]  cid;
    } t_cmd;

    // effective consumer count: zero acts as one, saturate at the maximum
    function automatic logic [CFG_W-1:0] active_count(input logic [CFG_W-1:0] cfg);
        logic [CFG_W-1:0] res;
        res = cfg;
        if (cfg == '0) begin
            res = CFG_W'(1);
        end else if (cfg > CFG_W'(MAX_CONS)) begin
            res = CFG_W'(MAX_CONS);
        end
        return res;
    endfunction

endpackage

// ----- hdl/bfmr_if.sv -----
// request and response channel interfaces
interface bfmr_req_if;
    logic                          valid;
    logic                          ready;
    logic [bfmr_pkg::REQ_W-1:0]    req_type;
    logic [bfmr_pkg::DATA_W-1:0]   push_data;
    logic [bfmr_pkg::CID_W-1:0]    consumer_id;

    modport source (output valid, req_type, push_data, consumer_id, input ready);
    modport sink   (input valid, req_type, push_data, consumer_id, output ready);
endinterface

interface bfmr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bfmr_pkg::STAT_W-1:0]   status;
    logic [bfmr_pkg::DATA_W-1:0]   pop_data;

    modport source (output valid, status, pop_data, input ready);
    modport sink   (input valid, status, pop_data, output ready);
endinterface

// ----- hdl/bfmr_ram.sv -----
// generic single-write single-read ram with registered read data
module bfmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bfmr_front.sv -----
// front end: accepts requests and classifies them into commands
module bfmr_front (
    bfmr_req_if.sink                       i_req,
    input  logic [bfmr_pkg::CFG_W-1:0]     i_active,
    input  logic                           i_cmd_ready,
    output logic                           o_cmd_valid,
    output bfmr_pkg::t_cmd                 o_cmd
);

    bfmr_pkg::t_op w_op;

    // request is taken whenever the command queue has room
    assign i_req.ready = i_cmd_ready;
    assign o_cmd_valid = i_req.valid;

    // classify, catching a bad consumer up front
    always_comb begin
        case (i_req.req_type)
            bfmr_pkg::REQ_PUSH: begin
                w_op = bfmr_pkg::OP_PUSH;
            end
            bfmr_pkg::REQ_POP: begin
                if (bfmr_pkg::CFG_W'(i_req.consumer_id) >= i_active) begin
                    w_op = bfmr_pkg::OP_BADC;
                end else begin
                    w_op = bfmr_pkg::OP_POP;
                end
            end
            bfmr_pkg::REQ_CLEAR: begin
                w_op = bfmr_pkg::OP_CLEAR;
            end
            default: begin
                w_op = bfmr_pkg::OP_NOP;
            end
        endcase
    end

    assign o_cmd.op   = w_op;
    assign o_cmd.data = i_req.push_data;
    assign o_cmd.cid  = i_req.consumer_id;

endmodule

// ----- hdl/bfmr_cmdq.sv -----
// short command queue between front end and back end
module bfmr_cmdq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  bfmr_pkg::t_cmd                  i_cmd,
    output logic                            o_ready,
    output logic                            o_valid,
    output bfmr_pkg::t_cmd                  o_cmd,
    input  logic                            i_pop,
    output logic [bfmr_pkg::QCNT_W-1:0]     o_count
);

    bfmr_pkg::t_cmd                     r_mem [bfmr_pkg::QDEPTH];
    logic [bfmr_pkg::QADDR_W-1:0]       r_head, n_head;
    logic [bfmr_pkg::QADDR_W-1:0]       r_tail, n_tail;
    logic [bfmr_pkg::QCNT_W-1:0]        r_count, n_count;
    logic                               w_wr;
    logic                               w_rd;

    assign o_ready = (r_count != bfmr_pkg::QCNT_W'(bfmr_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_head];
    assign o_count = r_count;

    assign w_wr = i_push && o_ready;
    assign w_rd = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (w_wr) begin
            n_tail = (r_tail == bfmr_pkg::QADDR_W'(bfmr_pkg::QDEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (w_rd) begin
            n_head = (r_head == bfmr_pkg::QADDR_W'(bfmr_pkg::QDEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_tail] <= i_cmd;
        end
    end

endmodule

// ----- hdl/bfmr_back.sv -----
// back end: executes commands against the fifo state and drives responses
module bfmr_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clear,
    input  logic [bfmr_pkg::CFG_W-1:0]      i_active,
    input  logic                            i_cmd_valid,
    input  bfmr_pkg::t_cmd                  i_cmd,
    output logic                            o_cmd_ready,
    bfmr_rsp_if.source                      o_rsp,
    output logic [bfmr_pkg::CNT_W-1:0]      o_free_slots
);

    logic [bfmr_pkg::CFG_W-1:0]   r_pend   [bfmr_pkg::DEPTH];
    logic [bfmr_pkg::CFG_W-1:0]   n_pend   [bfmr_pkg::DEPTH];
    logic [bfmr_pkg::ADDR_W-1:0]  r_rptr   [bfmr_pkg::MAX_CONS];
    logic [bfmr_pkg::ADDR_W-1:0]  n_rptr   [bfmr_pkg::MAX_CONS];
    logic [bfmr_pkg::CNT_W-1:0]   r_unread [bfmr_pkg::MAX_CONS];
    logic [bfmr_pkg::CNT_W-1:0]   n_unread [bfmr_pkg::MAX_CONS];
    logic [bfmr_pkg::ADDR_W-1:0]  r_wptr, n_wptr;
    logic [bfmr_pkg::CNT_W-1:0]   r_free, n_free;

    logic                         r_s1_valid;
    bfmr_pkg::t_status            r_s1_status;
    logic                         r_s1_rd;
    logic                         r_ov;
    bfmr_pkg::t_status            r_ostat;
    logic [bfmr_pkg::DATA_W-1:0]  r_odata;

    logic                         w_s1_move;
    logic                         w_exec;
    logic [bfmr_pkg::ADDR_W-1:0]  w_raddr;
    logic [bfmr_pkg::CFG_W-1:0]   w_rpend;
    bfmr_pkg::t_status            w_status;
    logic                         w_rd_ok;
    logic                         w_we;
    logic [bfmr_pkg::DATA_W-1:0]  w_rdata;

    // execute when the response stage below can move on
    assign w_s1_move   = !r_s1_valid || !r_ov || o_rsp.ready;
    assign w_exec      = i_cmd_valid && w_s1_move;
    assign o_cmd_ready = w_s1_move;

    assign w_raddr = r_rptr[i_cmd.cid];
    assign w_rpend = r_pend[w_raddr];

    // next state of pointers and counts for a clear or one command
    always_comb begin
        n_pend   = r_pend;
        n_rptr   = r_rptr;
        n_unread = r_unread;
        n_wptr   = r_wptr;
        n_free   = r_free;
        w_status = bfmr_pkg::ST_OK;
        w_rd_ok  = 1'b0;
        w_we     = 1'b0;
        if (i_clear) begin
            for (int s = 0; s < bfmr_pkg::DEPTH; s++) begin
                n_pend[s] = '0;
            end
            for (int c = 0; c < bfmr_pkg::MAX_CONS; c++) begin
                n_rptr[c]   = '0;
                n_unread[c] = '0;
            end
            n_wptr = '0;
            n_free = bfmr_pkg::CNT_W'(bfmr_pkg::DEPTH);
        end else if (w_exec) begin
            case (i_cmd.op)
                bfmr_pkg::OP_PUSH: begin
                    if (r_free == '0) begin
                        w_status = bfmr_pkg::ST_FULL;
                    end else begin
                        w_we = 1'b1;
                        n_pend[r_wptr] = i_active;
                        for (int c = 0; c < bfmr_pkg::MAX_CONS; c++) begin
                            if (bfmr_pkg::CFG_W'(c) < i_active) begin
                                n_unread[c] = r_unread[c] + 1'b1;
                            end
                        end
                        n_wptr = (r_wptr == bfmr_pkg::ADDR_W'(bfmr_pkg::DEPTH - 1)) ?
                                 '0 : r_wptr + 1'b1;
                        n_free = r_free - 1'b1;
                    end
                end
                bfmr_pkg::OP_POP: begin
                    if (r_unread[i_cmd.cid] == '0) begin
                        w_status = bfmr_pkg::ST_EMPTY;
                    end else begin
                        w_rd_ok = 1'b1;
                        if (w_rpend != '0) begin
                            n_pend[w_raddr] = w_rpend - 1'b1;
                            if (w_rpend == bfmr_pkg::CFG_W'(1) &&
                                r_free < bfmr_pkg::CNT_W'(bfmr_pkg::DEPTH)) begin
                                n_free = r_free + 1'b1;
                            end
                        end
                        n_rptr[i_cmd.cid] = (w_raddr == bfmr_pkg::ADDR_W'(bfmr_pkg::DEPTH - 1)) ?
                                            '0 : w_raddr + 1'b1;
                        n_unread[i_cmd.cid] = r_unread[i_cmd.cid] - 1'b1;
                    end
                end
                bfmr_pkg::OP_CLEAR: begin
                    for (int s = 0; s < bfmr_pkg::DEPTH; s++) begin
                        n_pend[s] = '0;
                    end
                    for (int c = 0; c < bfmr_pkg::MAX_CONS; c++) begin
                        n_rptr[c]   = '0;
                        n_unread[c] = '0;
                    end
                    n_wptr = '0;
                    n_free = bfmr_pkg::CNT_W'(bfmr_pkg::DEPTH);
                end
                bfmr_pkg::OP_BADC: begin
                    w_status = bfmr_pkg::ST_BADC;
                end
                default: begin
                    w_status = bfmr_pkg::ST_OK;
                end
            endcase
        end
    end

    // fifo state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < bfmr_pkg::DEPTH; s++) begin
                r_pend[s] <= '0;
            end
            for (int c = 0; c < bfmr_pkg::MAX_CONS; c++) begin
                r_rptr[c]   <= '0;
                r_unread[c] <= '0;
            end
            r_wptr <= '0;
            r_free <= bfmr_pkg::CNT_W'(bfmr_pkg::DEPTH);
        end else begin
            r_pend   <= n_pend;
            r_rptr   <= n_rptr;
            r_unread <= n_unread;
            r_wptr   <= n_wptr;
            r_free   <= n_free;
        end
    end

    // word storage
    bfmr_ram #(
        .WIDTH (bfmr_pkg::DATA_W),
        .DEPTH (bfmr_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wptr),
        .i_wdata (i_cmd.data),
        .i_re    (w_rd_ok),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // stage waiting for the ram read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_s1_valid <= w_exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_s1_status <= w_status;
            r_s1_rd     <= w_rd_ok;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_s1_valid && (!r_ov || o_rsp.ready)) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && (!r_ov || o_rsp.ready)) begin
            r_ostat <= r_s1_status;
            r_odata <= r_s1_rd ? w_rdata : '0;
        end
    end

    assign o_rsp.valid    = r_ov;
    assign o_rsp.status   = r_ostat;
    assign o_rsp.pop_data = r_odata;
    assign o_free_slots   = r_free;

endmodule

// ----- hdl/broadcast_fifo_multi_reader_unit.sv -----
// top level of the multi-reader broadcast fifo
//
// Requests arrive on i_req (valid/ready): push a word, pop for one consumer,
// clear the queue or do nothing. Every request gives exactly one response on
// o_rsp (valid/ready) with a status and, for a successful pop, the word read.
// A word leaves the queue only once each of the configured consumers has
// popped it. i_cfg_we with i_cfg_wdata sets the consumer count and clears the
// queue; the user must write it only while no request is in flight, as the
// block itself does not enforce this. An accepted request passes the
// four-entry command queue, then the back end state update and word store
// read, then the response register, which drives o_rsp.valid. One request
// per cycle is sustained while the receiver keeps taking responses.
// Reset empties the queue and sets the consumer count to one; the word store
// itself is not cleared. When the receiver stalls the response register holds,
// the back end stops and the command queue fills, then i_req.ready drops.
`include "broadcast_fifo_multi_reader_unit_defines.svh"

module broadcast_fifo_multi_reader_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bfmr_req_if.sink                      i_req,
    bfmr_rsp_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [bfmr_pkg::CFG_W-1:0]    i_cfg_wdata
);

    logic [bfmr_pkg::CFG_W-1:0]   r_cfg;
    logic [bfmr_pkg::CFG_W-1:0]   w_active;
    logic                         w_fr_valid;
    bfmr_pkg::t_cmd               w_fr_cmd;
    logic                         w_q_ready;
    logic                         w_q_valid;
    bfmr_pkg::t_cmd               w_q_cmd;
    logic                         w_bk_ready;
    logic [bfmr_pkg::QCNT_W-1:0]  w_q_count;
    logic [bfmr_pkg::CNT_W-1:0]   w_free;

    // consumer count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bfmr_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    assign w_active = bfmr_pkg::active_count(r_cfg);

    // request classification
    bfmr_front u_front (
        .i_req       (i_req),
        .i_active    (w_active),
        .i_cmd_ready (w_q_ready),
        .o_cmd_valid (w_fr_valid),
        .o_cmd       (w_fr_cmd)
    );

    // decoupling queue
    bfmr_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_valid),
        .i_cmd   (w_fr_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_bk_ready),
        .o_count (w_q_count)
    );

    // execution and response
    bfmr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (i_cfg_we),
        .i_active     (w_active),
        .i_cmd_valid  (w_q_valid),
        .i_cmd        (w_q_cmd),
        .o_cmd_ready  (w_bk_ready),
        .o_rsp        (o_rsp),
        .o_free_slots (w_free)
    );

    // checks
    `BFMR_ASSERT_IMPLY(a_free_range, 1'b1, w_free <= bfmr_pkg::CNT_W'(bfmr_pkg::DEPTH), "free slot count above depth")
    `BFMR_ASSERT_NEXT(a_cfg_clears, i_cfg_we, w_free == bfmr_pkg::CNT_W'(bfmr_pkg::DEPTH), "consumer count write did not clear the queue")
    `BFMR_ASSERT_IMPLY(a_full_stall, w_q_count == bfmr_pkg::QCNT_W'(bfmr_pkg::QDEPTH), !i_req.ready, "request taken with command queue full")
    `BFMR_ASSERT_IMPLY(a_fail_zero, o_rsp.valid && o_rsp.status != bfmr_pkg::ST_OK, o_rsp.pop_data == '0, "failed request returned data")

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the multi-reader broadcast fifo
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_LIMIT     = 500;
    localparam int RANDOM_PHASE   = 135;
    localparam int SUBPHASE_LEN   = 45;
    localparam int MAX_PRINTED    = 100;

    typedef struct {
        bfmr_pkg::t_status           status;
        logic [bfmr_pkg::DATA_W-1:0] word;
    } t_reply;

    typedef struct {
        logic [bfmr_pkg::REQ_W-1:0]  kind;
        logic [bfmr_pkg::DATA_W-1:0] word;
        logic [bfmr_pkg::CID_W-1:0]  who;
        int                          reps;
        bit                          typed;
        bfmr_pkg::t_status           status;
        logic [bfmr_pkg::DATA_W-1:0] rd;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [bfmr_pkg::CFG_W-1:0] i_cfg_wdata;

    bfmr_req_if req_ch ();
    bfmr_rsp_if rsp_ch ();

    broadcast_fifo_multi_reader_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // queue state as the block should hold it
    logic [bfmr_pkg::DATA_W-1:0] stored_words [bfmr_pkg::DEPTH];
    int                          readers_left [bfmr_pkg::DEPTH];
    int                          next_read    [bfmr_pkg::MAX_CONS];
    int                          unread_cnt   [bfmr_pkg::MAX_CONS];
    int                          next_write;
    int                          free_cnt;
    logic [bfmr_pkg::CFG_W-1:0]  consumer_cfg;

    t_reply owed_replies [$];
    int     mismatch_count = 0;
    int     idle_cycles    = 0;

    // expectation typed into the table for the request now on the channel
    bit                          row_typed  = 1'b0;
    bfmr_pkg::t_status           row_status = bfmr_pkg::ST_OK;
    logic [bfmr_pkg::DATA_W-1:0] row_word   = '0;

    bit req_no_gaps = 1'b0;

    // directed requests, walked after reset with one consumer
    t_stim_row directed_rows [12] = '{
        '{bfmr_pkg::REQ_POP, 32'h0, 3'd0, 1, 1'b1, bfmr_pkg::ST_EMPTY, 32'h0},
        '{bfmr_pkg::REQ_POP, 32'h0, 3'd7, 1, 1'b1, bfmr_pkg::ST_BADC, 32'h0},
        '{bfmr_pkg::REQ_NOP, 32'hFFFF_FFFF, 3'd5, 1, 1'b1, bfmr_pkg::ST_OK, 32'h0},
        '{bfmr_pkg::REQ_CLEAR, 32'h0, 3'd0, 1, 1'b1, bfmr_pkg::ST_OK, 32'h0},
        '{bfmr_pkg::REQ_PUSH, 32'hFFFF_FFFF, 3'd0, 1, 1'b1, bfmr_pkg::ST_OK, 32'h0},
        '{bfmr_pkg::REQ_POP, 32'h0, 3'd0, 1, 1'b1, bfmr_pkg::ST_OK, 32'hFFFF_FFFF},
        '{bfmr_pkg::REQ_POP, 32'h0, 3'd0, 1, 1'b1, bfmr_pkg::ST_EMPTY, 32'h0},
        '{bfmr_pkg::REQ_PUSH, 32'h0, 3'd2, 16, 1'b1, bfmr_pkg::ST_OK, 32'h0},
        '{bfmr_pkg::REQ_PUSH, 32'h8000_0001, 3'd3, 1, 1'b1, bfmr_pkg::ST_FULL, 32'h0},
        '{bfmr_pkg::REQ_POP, 32'h0, 3'd0, 1, 1'b0, bfmr_pkg::ST_OK, 32'h0},
        '{bfmr_pkg::REQ_CLEAR, 32'h0, 3'd6, 1, 1'b1, bfmr_pkg::ST_OK, 32'h0},
        '{bfmr_pkg::REQ_POP, 32'h0, 3'd0, 1, 1'b1, bfmr_pkg::ST_EMPTY, 32'h0}
    };

    // consumer count written before each later random phase
    logic [bfmr_pkg::CFG_W-1:0] cfg_settings [9] = '{
        4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd12, 4'd6, 4'd2, 4'd5
    };

    // zero acts as one, large values saturate
    function automatic int readers_per_word(input logic [bfmr_pkg::CFG_W-1:0] cfg);
        int n;
        n = int'(cfg);
        if (n == 0) begin
            n = 1;
        end else if (n > bfmr_pkg::MAX_CONS) begin
            n = bfmr_pkg::MAX_CONS;
        end
        return n;
    endfunction

    function automatic void model_flush();
        for (int s = 0; s < bfmr_pkg::DEPTH; s++) begin
            readers_left[s] = 0;
        end
        for (int c = 0; c < bfmr_pkg::MAX_CONS; c++) begin
            next_read[c]  = 0;
            unread_cnt[c] = 0;
        end
        next_write = 0;
        free_cnt   = bfmr_pkg::DEPTH;
    endfunction

    // one request applied to the queue state, giving the reply it owes
    function automatic void fifo_step(input logic [bfmr_pkg::REQ_W-1:0] kind,
                                      input logic [bfmr_pkg::DATA_W-1:0] word,
                                      input logic [bfmr_pkg::CID_W-1:0] who,
                                      output t_reply reply);
        int n;
        int slot;
        n = readers_per_word(consumer_cfg);
        reply.status = bfmr_pkg::ST_OK;
        reply.word   = '0;
        case (kind)
            bfmr_pkg::REQ_PUSH: begin
                if (free_cnt == 0) begin
                    reply.status = bfmr_pkg::ST_FULL;
                end else begin
                    stored_words[next_write] = word;
                    readers_left[next_write] = n;
                    for (int c = 0; c < n; c++) begin
                        unread_cnt[c]++;
                    end
                    next_write = (next_write + 1) % bfmr_pkg::DEPTH;
                    free_cnt--;
                end
            end
            bfmr_pkg::REQ_POP: begin
                if (int'(who) >= n) begin
                    reply.status = bfmr_pkg::ST_BADC;
                end else if (unread_cnt[who] == 0) begin
                    reply.status = bfmr_pkg::ST_EMPTY;
                end else begin
                    slot       = next_read[who];
                    reply.word = stored_words[slot];
                    if (readers_left[slot] != 0) begin
                        readers_left[slot]--;
                        if (readers_left[slot] == 0 && free_cnt < bfmr_pkg::DEPTH) begin
                            free_cnt++;
                        end
                    end
                    next_read[who] = (slot + 1) % bfmr_pkg::DEPTH;
                    unread_cnt[who]--;
                end
            end
            bfmr_pkg::REQ_CLEAR: begin
                model_flush();
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    // prediction, reply checking and watchdog, all on the rising edge
    always @(posedge i_clk) begin : scoreboard
        t_reply want;
        t_reply predicted;
        if (!i_rst_n) begin
            model_flush();
            consumer_cfg = 4'd1;
            idle_cycles  = 0;
        end else begin
            // check the reply taken at this edge
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (owed_replies.size() == 0) begin
                    report_mismatch($sformatf("reply with no request outstanding, status %0d",
                                              rsp_ch.status));
                end else begin
                    want = owed_replies.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_ch.status, want.status));
                    end
                    if (rsp_ch.pop_data !== want.word) begin
                        report_mismatch($sformatf("pop_data %h, expected %h",
                                                  rsp_ch.pop_data, want.word));
                    end
                end
            end
            // a consumer count write also empties the queue
            if (i_cfg_we) begin
                consumer_cfg = i_cfg_wdata;
                model_flush();
            end
            // predict the reply for the request taken at this edge
            if (req_ch.valid && req_ch.ready) begin
                fifo_step(req_ch.req_type, req_ch.push_data, req_ch.consumer_id, predicted);
                if (row_typed) begin
                    want.status = row_status;
                    want.word   = row_word;
                    owed_replies.push_back(want);
                end else begin
                    owed_replies.push_back(predicted);
                end
            end
            // watchdog on cycles with no handshake
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // reply side: random stalls, with stretches of none
    initial begin : reply_sink
        int  stall;
        bit  no_stall;
        no_stall      = 1'b0;
        rsp_ch.ready  = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                no_stall = !no_stall;
            end
            stall = no_stall ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready = 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            @(negedge i_clk);
        end
    end

    // one request, held until taken; entered and left at a falling edge
    task automatic send_request(input logic [bfmr_pkg::REQ_W-1:0] kind,
                                input logic [bfmr_pkg::DATA_W-1:0] word,
                                input logic [bfmr_pkg::CID_W-1:0] who,
                                input bit typed,
                                input bfmr_pkg::t_status status,
                                input logic [bfmr_pkg::DATA_W-1:0] rd);
        int gap;
        gap = req_no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.req_type    = kind;
        req_ch.push_data   = word;
        req_ch.consumer_id = who;
        row_typed          = typed;
        row_status         = status;
        row_word           = rd;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // wait for every reply, then write the consumer count
    task automatic write_consumer_count(input logic [bfmr_pkg::CFG_W-1:0] value);
        req_ch.valid = 1'b0;
        while (owed_replies.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // random requests, mostly for valid consumers, push share varied
    task automatic run_random_phase(input int count);
        int push_pct;
        int roll;
        int n;
        logic [bfmr_pkg::REQ_W-1:0]  kind;
        logic [bfmr_pkg::DATA_W-1:0] word;
        logic [bfmr_pkg::CID_W-1:0]  who;
        push_pct = 35;
        for (int i = 0; i < count; i++) begin
            if (i % SUBPHASE_LEN == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 35;
                    default: push_pct = 60;
                endcase
                req_no_gaps = ($urandom_range(0, 3) == 0);
            end
            n    = readers_per_word(consumer_cfg);
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                kind = bfmr_pkg::REQ_CLEAR;
            end else if (roll < 5) begin
                kind = bfmr_pkg::REQ_NOP;
            end else if (roll < 5 + push_pct) begin
                kind = bfmr_pkg::REQ_PUSH;
            end else begin
                kind = bfmr_pkg::REQ_POP;
            end
            case ($urandom_range(0, 19))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            if ($urandom_range(0, 99) < 85) begin
                who = bfmr_pkg::CID_W'($urandom_range(0, n - 1));
            end else begin
                who = bfmr_pkg::CID_W'($urandom_range(0, bfmr_pkg::MAX_CONS - 1));
            end
            send_request(kind, word, who, 1'b0, bfmr_pkg::ST_OK, '0);
        end
    endtask

    // reset, directed table, random phases over the consumer counts, end
    initial begin : stimulus
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = bfmr_pkg::REQ_NOP;
        req_ch.push_data   = '0;
        req_ch.consumer_id = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part, pushes in a repeated row step by a repeating nibble
        foreach (directed_rows[k]) begin
            for (int j = 0; j < directed_rows[k].reps; j++) begin
                req_no_gaps = ($urandom_range(0, 2) == 0);
                send_request(directed_rows[k].kind,
                             directed_rows[k].word + bfmr_pkg::DATA_W'(j) * 32'h1111_1111,
                             directed_rows[k].who, directed_rows[k].typed,
                             directed_rows[k].status, directed_rows[k].rd);
            end
        end

        run_random_phase(RANDOM_PHASE);
        foreach (cfg_settings[p]) begin
            write_consumer_count(cfg_settings[p]);
            run_random_phase(RANDOM_PHASE);
        end

        // drain and let the pipeline settle
        req_ch.valid = 1'b0;
        while (owed_replies.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
